// ===== rtl/pt2d_pkg.sv =====
// Package: command codes, sequencer states and constants of the 2D tessellator.
package pt2d_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [2:0] {
        CMD_RECT   = 3'd0,
        CMD_LINE   = 3'd1,
        CMD_TRI    = 3'd2,
        CMD_FCIRC  = 3'd3,
        CMD_OCIRC  = 3'd4,
        CMD_RESET  = 3'd5,
        CMD_RSVD6  = 3'd6,
        CMD_RSVD7  = 3'd7
    } t_cmd;

    localparam logic KIND_QUAD = 1'b0;
    localparam logic KIND_TRI  = 1'b1;

    // CORDIC arc table in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] v;
        begin
            unique case (i)
                5'd0: v = 30'd536870912;  5'd1: v = 30'd316933406;
                5'd2: v = 30'd167458907;  5'd3: v = 30'd85004756;
                5'd4: v = 30'd42667331;   5'd5: v = 30'd21354465;
                5'd6: v = 30'd10679838;   5'd7: v = 30'd5340245;
                5'd8: v = 30'd2670163;    5'd9: v = 30'd1335087;
                5'd10: v = 30'd667544;    5'd11: v = 30'd333772;
                5'd12: v = 30'd166886;    5'd13: v = 30'd83443;
                5'd14: v = 30'd41722;     5'd15: v = 30'd20861;
                5'd16: v = 30'd10430;     5'd17: v = 30'd5215;
                5'd18: v = 30'd2608;      5'd19: v = 30'd1304;
                5'd20: v = 30'd652;       5'd21: v = 30'd326;
                5'd22: v = 30'd163;       5'd23: v = 30'd81;
                5'd24: v = 30'd41;        5'd25: v = 30'd20;
                5'd26: v = 30'd10;        5'd27: v = 30'd5;
                5'd28: v = 30'd3;         5'd29: v = 30'd1;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SPAN_START,
        ST_PH_DIV,
        ST_CORDIC,
        ST_MUL_X,
        ST_MUL_Y,
        ST_PT_DONE,
        ST_LINE_START,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQRT,
        ST_MUL_TDY,
        ST_DIV_OX,
        ST_MUL_TDX,
        ST_DIV_OY,
        ST_CORNERS,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/pt2d_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by the phase and offset divides.
module pt2d_divider #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_sub;

    // one shift-and-subtract step
    assign w_trial = {r_rem[DEN_W-1:0], r_quot[NUM_W-1]};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!w_sub[DEN_W]) begin
                r_rem  <= w_sub;
                r_quot <= {r_quot[NUM_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_trial;
                r_quot <= {r_quot[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== rtl/primitive_tessellator_2d.sv =====
// Top level of the 2D tessellator: sequencer with shared multiplier, divider and CORDIC.
//
// Usage: one command transaction enters on i_* with i_valid/o_ready; the block
// emits zero or more primitive transactions on o_* with o_valid/i_ready.
// o_ready is high only when the sequencer is idle; one command is worked at
// a time.
// Work per command:
//   rect and triangle: dispatch goes straight to the output state.
//   line: the 26-step bit-serial square root, then two 64-step divides
//   through the one shared divider (skipped when the length is zero).
//   circle: per slice two points, each a 64-step phase divide, 30 CORDIC
//   steps and two multiplies; an outline slice adds the line path. The
//   divider and the CORDIC loop take most of the time.
// Reset command, a circle with zero span count and unknown commands emit nothing.
// Reset (i_rst_n low, synchronous) clears the sequencer, output valid and the
// base index counter. When the receiver stalls, the output register holds the
// primitive and the sequencer waits; no command is lost.
module primitive_tessellator_2d #(
    parameter int MAX_SPANS   = 64,
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_command,
    input  logic signed [COORD_WIDTH-1:0] i_point_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_b_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_c_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_c_y,
    input  logic [15:0]                   i_line_thickness,
    input  logic [21:0]                   i_radius,
    input  logic [6:0]                    i_span_count,
    input  logic [23:0]                   i_color_rgb,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_prim_kind,
    output logic [15:0]                   o_base_index,
    output logic signed [COORD_WIDTH-1:0] o_corner1_x,
    output logic signed [COORD_WIDTH-1:0] o_corner1_y,
    output logic signed [COORD_WIDTH-1:0] o_corner2_x,
    output logic signed [COORD_WIDTH-1:0] o_corner2_y,
    output logic signed [COORD_WIDTH-1:0] o_corner3_x,
    output logic signed [COORD_WIDTH-1:0] o_corner3_y,
    output logic signed [COORD_WIDTH-1:0] o_corner4_x,
    output logic signed [COORD_WIDTH-1:0] o_corner4_y,
    output logic [23:0]                   o_color_out,
    output logic                          o_last_of_run
);
    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;           // |difference| width
    localparam int SQW  = 2 * DW + 2;       // dx^2+dy^2 width, even for bit pairs
    localparam int LW   = DW + 1;           // sqrt result width (half of SQW)
    localparam int NUMW = 64;
    localparam int DENW = LW + 2;
    localparam int SPW  = $clog2(MAX_SPANS + 1);
    localparam logic signed [CW+1:0] SAT_HI = (CW+2)'((64'sd1 <<< (CW - 1)) - 1);
    localparam logic signed [CW+1:0] SAT_LO = -SAT_HI - 1;

    typedef logic signed [CW+1:0] t_wide;

    pt2d_pkg::t_state r_state, n_state;

    // command registers
    pt2d_pkg::t_cmd r_cmd;
    logic signed [CW-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [15:0] r_t;
    logic [21:0] r_r;
    logic [SPW-1:0] r_spans, r_slice;
    logic [23:0] r_color;
    logic [15:0] r_next_base;

    // circle point work
    logic        r_pt_sel;       // 0 first point, 1 second point of slice
    logic [SPW:0] w_k;
    logic [31:0] r_phase;
    logic signed [33:0] r_cx_c, r_cy_c;   // cordic x,y
    logic signed [31:0] r_cz;
    logic [4:0]  r_step;
    logic signed [CW-1:0] r_p0x, r_p0y, r_p1x, r_p1y;

    // line work
    logic signed [CW-1:0] r_lx0, r_ly0, r_lx1, r_ly1;
    logic [DW-1:0] r_dx, r_dy;
    logic [SQW-1:0] r_sq;
    logic [SQW-1:0] r_sq_rem;
    logic [LW-1:0]  r_len;
    logic [5:0]     r_sq_cnt;
    logic [CW:0]    r_ox, r_oy;

    // shared multiplier product register
    logic signed [63:0] r_prod;

    // output register
    logic r_ovalid, r_okind, r_olast;
    logic [15:0] r_obase;
    logic signed [CW-1:0] r_oc [8];
    logic [23:0] r_ocolor;

    // divider
    logic            w_div_start;
    logic [NUMW-1:0] w_div_num;
    logic [DENW-1:0] w_div_den;
    logic            w_div_done;
    logic [NUMW-1:0] w_div_quot;

    pt2d_divider #(.NUM_W(NUMW), .DEN_W(DENW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (w_div_den),
        .o_done (w_div_done),
        .o_quot (w_div_quot)
    );

    function automatic logic signed [CW-1:0] sat_c(input t_wide v);
        if (v > SAT_HI)      return SAT_HI[CW-1:0];
        else if (v < SAT_LO) return SAT_LO[CW-1:0];
        else                 return v[CW-1:0];
    endfunction

    // shared multiplier operand selection (one multiply per cycle)
    logic signed [34:0] w_ma;
    logic signed [34:0] w_mb;
    logic signed [69:0] w_mp;
    logic signed [33:0] w_co, w_si;

    always_comb begin
        unique case (r_phase[31:30])
            2'd0: begin w_co = r_cx_c;  w_si = r_cy_c;  end
            2'd1: begin w_co = -r_cy_c; w_si = r_cx_c;  end
            2'd2: begin w_co = -r_cx_c; w_si = -r_cy_c; end
            default: begin w_co = r_cy_c; w_si = -r_cx_c; end
        endcase
    end

    always_comb begin
        unique case (r_state)
            pt2d_pkg::ST_MUL_X:   begin w_ma = 35'(w_co); w_mb = 35'({1'b0, r_r}); end
            pt2d_pkg::ST_MUL_Y:   begin w_ma = 35'(w_si); w_mb = 35'({1'b0, r_r}); end
            pt2d_pkg::ST_SQ_X:    begin w_ma = 35'({1'b0, r_dx}); w_mb = 35'({1'b0, r_dx}); end
            pt2d_pkg::ST_SQ_Y:    begin w_ma = 35'({1'b0, r_dy}); w_mb = 35'({1'b0, r_dy}); end
            pt2d_pkg::ST_MUL_TDY: begin w_ma = 35'({1'b0, r_dy}); w_mb = 35'({1'b0, r_t}); end
            pt2d_pkg::ST_MUL_TDX: begin w_ma = 35'({1'b0, r_dx}); w_mb = 35'({1'b0, r_t}); end
            default:              begin w_ma = '0; w_mb = '0; end
        endcase
        w_mp = w_ma * w_mb;
    end

    // isqrt step (bit-serial, two radicand bits per step)
    logic [SQW+1:0] w_sq_trial;
    logic [SQW+1:0] w_sq_rem_sh;
    logic [SQW+1:0] w_sq_sub;
    assign w_sq_rem_sh = {r_sq_rem, r_sq[SQW-1 -: 2]};
    assign w_sq_trial  = (SQW+2)'({r_len, 2'b01});
    assign w_sq_sub    = w_sq_rem_sh - w_sq_trial;

    // cordic step
    logic signed [33:0] w_xs, w_ys;
    assign w_xs = r_cx_c >>> r_step;
    assign w_ys = r_cy_c >>> r_step;

    // point from product: center + ((r*cos + 2^29) >>> 30)
    logic signed [63:0] w_rnd;
    logic signed [CW-1:0] w_ctr;
    t_wide w_pt;
    assign w_rnd = (w_mp[63:0] + 64'sd536870912) >>> 30;
    assign w_ctr = (r_state == pt2d_pkg::ST_MUL_X) ? r_ax : r_ay;
    assign w_pt  = t_wide'(w_ctr) + t_wide'($signed(w_rnd[CW:0])) ;

    // line corners
    logic signed [1:0] w_sa, w_sb;
    t_wide w_c [8];
    always_comb begin
        if (r_lx1 > r_lx0 && r_ly1 > r_ly0)      begin w_sa = 2'sd1;  w_sb = -2'sd1; end
        else if (r_lx1 > r_lx0 && r_ly1 < r_ly0) begin w_sa = -2'sd1; w_sb = -2'sd1; end
        else if (r_lx1 < r_lx0 && r_ly1 < r_ly0) begin w_sa = -2'sd1; w_sb = 2'sd1;  end
        else                                      begin w_sa = 2'sd1;  w_sb = 2'sd1;  end
    end
    t_wide w_sox, w_soy;
    assign w_sox = (w_sa > 0) ? t_wide'({1'b0, r_ox}) : -t_wide'({1'b0, r_ox});
    assign w_soy = (w_sb > 0) ? t_wide'({1'b0, r_oy}) : -t_wide'({1'b0, r_oy});
    always_comb begin
        w_c[0] = t_wide'(r_lx0) + w_sox; w_c[1] = t_wide'(r_ly0) + w_soy;
        w_c[2] = t_wide'(r_lx0) - w_sox; w_c[3] = t_wide'(r_ly0) - w_soy;
        w_c[4] = t_wide'(r_lx1) + w_sox; w_c[5] = t_wide'(r_ly1) + w_soy;
        w_c[6] = t_wide'(r_lx1) - w_sox; w_c[7] = t_wide'(r_ly1) - w_soy;
    end

    logic w_accept, w_out_free, w_last_slice;
    assign w_accept     = i_valid && o_ready;
    assign w_out_free   = !r_ovalid || i_ready;
    assign w_last_slice = (r_slice == r_spans - 1'b1);

    // rim point index: k=i+2 at slice start, then k=i+1
    assign w_k = (r_state == pt2d_pkg::ST_SPAN_START) ? (SPW+1)'(r_slice) + 2'd2
                                                      : (SPW+1)'(r_slice) + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pt2d_pkg::ST_IDLE:       if (w_accept) n_state = pt2d_pkg::ST_DISPATCH;
            pt2d_pkg::ST_DISPATCH: begin
                unique case (r_cmd)
                    pt2d_pkg::CMD_RECT, pt2d_pkg::CMD_TRI: n_state = pt2d_pkg::ST_OUT;
                    pt2d_pkg::CMD_LINE:  n_state = pt2d_pkg::ST_LINE_START;
                    pt2d_pkg::CMD_FCIRC, pt2d_pkg::CMD_OCIRC:
                        n_state = (r_spans == '0) ? pt2d_pkg::ST_IDLE
                                                  : pt2d_pkg::ST_SPAN_START;
                    default: n_state = pt2d_pkg::ST_IDLE;
                endcase
            end
            pt2d_pkg::ST_SPAN_START: n_state = pt2d_pkg::ST_PH_DIV;
            pt2d_pkg::ST_PH_DIV:     if (w_div_done) n_state = pt2d_pkg::ST_CORDIC;
            pt2d_pkg::ST_CORDIC:     if (r_step == 5'(pt2d_pkg::CORDIC_STEPS - 1))
                                         n_state = pt2d_pkg::ST_MUL_X;
            pt2d_pkg::ST_MUL_X:      n_state = pt2d_pkg::ST_MUL_Y;
            pt2d_pkg::ST_MUL_Y:      n_state = pt2d_pkg::ST_PT_DONE;
            pt2d_pkg::ST_PT_DONE: begin
                if (!r_pt_sel) n_state = pt2d_pkg::ST_PH_DIV;
                else if (r_cmd == pt2d_pkg::CMD_OCIRC) n_state = pt2d_pkg::ST_LINE_START;
                else n_state = pt2d_pkg::ST_OUT;
            end
            pt2d_pkg::ST_LINE_START: n_state = pt2d_pkg::ST_SQ_X;
            pt2d_pkg::ST_SQ_X:       n_state = pt2d_pkg::ST_SQ_Y;
            pt2d_pkg::ST_SQ_Y:       n_state = pt2d_pkg::ST_SQRT;
            pt2d_pkg::ST_SQRT:       if (r_sq_cnt == 6'd1) n_state = pt2d_pkg::ST_MUL_TDY;
            pt2d_pkg::ST_MUL_TDY:    n_state = (r_len == '0) ? pt2d_pkg::ST_CORNERS
                                                             : pt2d_pkg::ST_DIV_OX;
            pt2d_pkg::ST_DIV_OX:     if (w_div_done) n_state = pt2d_pkg::ST_MUL_TDX;
            pt2d_pkg::ST_MUL_TDX:    n_state = pt2d_pkg::ST_DIV_OY;
            pt2d_pkg::ST_DIV_OY:     if (w_div_done) n_state = pt2d_pkg::ST_CORNERS;
            pt2d_pkg::ST_CORNERS:    n_state = pt2d_pkg::ST_OUT;
            pt2d_pkg::ST_OUT: begin
                if (w_out_free) begin
                    if ((r_cmd == pt2d_pkg::CMD_FCIRC || r_cmd == pt2d_pkg::CMD_OCIRC)
                        && !w_last_slice)
                        n_state = pt2d_pkg::ST_SPAN_START;
                    else
                        n_state = pt2d_pkg::ST_IDLE;
                end
            end
            default: n_state = pt2d_pkg::ST_IDLE;
        endcase
    end

    // divider requests: start on entry into a divide state
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        if (r_state == pt2d_pkg::ST_SPAN_START || (r_state == pt2d_pkg::ST_PT_DONE && !r_pt_sel)) begin
            w_div_start = 1'b1;
            w_div_num   = {w_k[SPW-1:0] == r_spans ? 32'd0 : 32'(w_k), 32'd0};
            w_div_den   = DENW'(r_spans);
        end else if (r_state == pt2d_pkg::ST_MUL_TDY && r_len != '0) begin
            w_div_start = 1'b1;
            w_div_num   = NUMW'(w_mp[63:0]) + NUMW'(r_len);
            w_div_den   = DENW'({r_len, 1'b0});
        end else if (r_state == pt2d_pkg::ST_MUL_TDX) begin
            w_div_start = 1'b1;
            w_div_num   = NUMW'(w_mp[63:0]) + NUMW'(r_len);
            w_div_den   = DENW'({r_len, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= pt2d_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_base <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (r_state == pt2d_pkg::ST_DISPATCH && r_cmd == pt2d_pkg::CMD_RESET)
                r_next_base <= '0;
            if (r_state == pt2d_pkg::ST_OUT && w_out_free) begin
                r_ovalid    <= 1'b1;
                r_next_base <= r_next_base +
                    ((r_cmd == pt2d_pkg::CMD_TRI || r_cmd == pt2d_pkg::CMD_FCIRC)
                        ? 16'd3 : 16'd4);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // capture command
        if (w_accept) begin
            r_cmd   <= pt2d_pkg::t_cmd'(i_command);
            r_ax    <= i_point_a_x; r_ay <= i_point_a_y;
            r_bx    <= i_point_b_x; r_by <= i_point_b_y;
            r_cx    <= i_point_c_x; r_cy <= i_point_c_y;
            r_t     <= i_line_thickness;
            r_r     <= i_radius;
            r_spans <= (i_span_count > 7'(MAX_SPANS)) ? SPW'(MAX_SPANS) : SPW'(i_span_count);
            r_color <= i_color_rgb;
            r_slice <= '0;
        end

        unique case (r_state)
            pt2d_pkg::ST_DISPATCH: begin
                r_lx0 <= r_ax; r_ly0 <= r_ay; r_lx1 <= r_bx; r_ly1 <= r_by;
            end
            pt2d_pkg::ST_SPAN_START: begin
                r_pt_sel <= 1'b0;
            end
            pt2d_pkg::ST_PH_DIV: begin
                if (w_div_done) begin
                    r_phase <= w_div_quot[31:0];
                    r_cx_c  <= pt2d_pkg::CORDIC_GAIN;
                    r_cy_c  <= '0;
                    r_cz    <= 32'sd0 + $signed({2'b00, w_div_quot[29:0]});
                    r_step  <= '0;
                end
            end
            pt2d_pkg::ST_CORDIC: begin
                if (!r_cz[31]) begin
                    r_cx_c <= r_cx_c - w_ys;
                    r_cy_c <= r_cy_c + w_xs;
                    r_cz   <= r_cz - $signed({2'b00, pt2d_pkg::atan_turn(r_step)});
                end else begin
                    r_cx_c <= r_cx_c + w_ys;
                    r_cy_c <= r_cy_c - w_xs;
                    r_cz   <= r_cz + $signed({2'b00, pt2d_pkg::atan_turn(r_step)});
                end
                r_step <= r_step + 1'b1;
            end
            pt2d_pkg::ST_MUL_X: begin
                if (!r_pt_sel) r_p0x <= sat_c(w_pt);
                else           r_p1x <= sat_c(w_pt);
            end
            pt2d_pkg::ST_MUL_Y: begin
                if (!r_pt_sel) r_p0y <= sat_c(w_pt);
                else           r_p1y <= sat_c(w_pt);
            end
            pt2d_pkg::ST_PT_DONE: begin
                // first point computed was k=i+2; then k=i+1
                r_pt_sel <= 1'b1;
                if (r_pt_sel) begin
                    r_lx0 <= r_p1x; r_ly0 <= r_p1y;
                    r_lx1 <= r_p0x; r_ly1 <= r_p0y;
                end
            end
            pt2d_pkg::ST_LINE_START: begin
                r_dx <= (r_lx1 > r_lx0) ? DW'(t_wide'(r_lx1) - t_wide'(r_lx0))
                                        : DW'(t_wide'(r_lx0) - t_wide'(r_lx1));
                r_dy <= (r_ly1 > r_ly0) ? DW'(t_wide'(r_ly1) - t_wide'(r_ly0))
                                        : DW'(t_wide'(r_ly0) - t_wide'(r_ly1));
                r_ox <= '0; r_oy <= '0;
            end
            pt2d_pkg::ST_SQ_X: r_prod <= w_mp[63:0];
            pt2d_pkg::ST_SQ_Y: begin
                r_sq     <= SQW'(r_prod) + SQW'(w_mp[63:0]);
                r_sq_rem <= '0;
                r_len    <= '0;
                r_sq_cnt <= 6'((SQW + 1) / 2);
            end
            pt2d_pkg::ST_SQRT: begin
                if (!w_sq_sub[SQW+1]) begin
                    r_sq_rem <= SQW'(w_sq_sub);
                    r_len    <= {r_len[LW-2:0], 1'b1};
                end else begin
                    r_sq_rem <= SQW'(w_sq_rem_sh);
                    r_len    <= {r_len[LW-2:0], 1'b0};
                end
                r_sq     <= {r_sq[SQW-3:0], 2'b00};
                r_sq_cnt <= r_sq_cnt - 1'b1;
            end
            pt2d_pkg::ST_MUL_TDY: r_prod <= w_mp[63:0];
            pt2d_pkg::ST_DIV_OX: if (w_div_done) r_ox <= (CW+1)'(w_div_quot);
            pt2d_pkg::ST_DIV_OY: if (w_div_done) r_oy <= (CW+1)'(w_div_quot);
            pt2d_pkg::ST_OUT: begin
                if (w_out_free) begin
                    r_slice  <= r_slice + 1'b1;
                    r_obase  <= r_next_base;
                    r_ocolor <= r_color;
                    r_olast  <= !((r_cmd == pt2d_pkg::CMD_FCIRC ||
                                   r_cmd == pt2d_pkg::CMD_OCIRC) && !w_last_slice);
                    unique case (r_cmd)
                        pt2d_pkg::CMD_RECT: begin
                            r_okind  <= pt2d_pkg::KIND_QUAD;
                            r_oc[0] <= r_ax; r_oc[1] <= r_ay;
                            r_oc[2] <= r_ax; r_oc[3] <= sat_c(t_wide'(r_ay) + t_wide'(r_by));
                            r_oc[4] <= sat_c(t_wide'(r_ax) + t_wide'(r_bx)); r_oc[5] <= r_ay;
                            r_oc[6] <= sat_c(t_wide'(r_ax) + t_wide'(r_bx));
                            r_oc[7] <= sat_c(t_wide'(r_ay) + t_wide'(r_by));
                        end
                        pt2d_pkg::CMD_TRI: begin
                            r_okind <= pt2d_pkg::KIND_TRI;
                            r_oc[0] <= r_ax; r_oc[1] <= r_ay;
                            r_oc[2] <= r_bx; r_oc[3] <= r_by;
                            r_oc[4] <= r_cx; r_oc[5] <= r_cy;
                            r_oc[6] <= '0;   r_oc[7] <= '0;
                        end
                        pt2d_pkg::CMD_FCIRC: begin
                            r_okind <= pt2d_pkg::KIND_TRI;
                            r_oc[0] <= r_ax;  r_oc[1] <= r_ay;
                            r_oc[2] <= r_p1x; r_oc[3] <= r_p1y;
                            r_oc[4] <= r_p0x; r_oc[5] <= r_p0y;
                            r_oc[6] <= '0;    r_oc[7] <= '0;
                        end
                        default: begin
                            r_okind <= pt2d_pkg::KIND_QUAD;
                            for (int j = 0; j < 8; j++) r_oc[j] <= sat_c(w_c[j]);
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign o_ready       = (r_state == pt2d_pkg::ST_IDLE);
    assign o_valid       = r_ovalid;
    assign o_prim_kind   = r_okind;
    assign o_base_index  = r_obase;
    assign o_corner1_x   = r_oc[0];
    assign o_corner1_y   = r_oc[1];
    assign o_corner2_x   = r_oc[2];
    assign o_corner2_y   = r_oc[3];
    assign o_corner3_x   = r_oc[4];
    assign o_corner3_y   = r_oc[5];
    assign o_corner4_x   = r_oc[6];
    assign o_corner4_y   = r_oc[7];
    assign o_color_out   = r_ocolor;
    assign o_last_of_run = r_olast;
endmodule

// ===== tb/testbench.sv =====
// Testbench for primitive_tessellator_2d: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

typedef struct {
    pt2d_pkg::t_cmd     cmd;
    logic signed [23:0] ax, ay, bx, by, cx, cy;
    logic [15:0]        thick;
    logic [21:0]        radius;
    logic [6:0]         spans;
    logic [23:0]        color;
} t_cmd_txn;

typedef struct {
    logic               kind;
    logic [15:0]        base;
    logic signed [23:0] c[8];
    logic [23:0]        color;
    logic               last;
} t_prim;

class prim_scoreboard;
    t_prim       expected_prims[$];
    logic [15:0] next_base;
    int          errors;
    int          mismatches;
    longint      arc_tbl[30];

    function new();
        arc_tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                    81, 41, 20, 10, 5, 3, 1};
        next_base = '0;
        errors = 0;
        mismatches = 0;
    endfunction

    function longint clamp(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function void push_prim(logic kind, longint c[8], logic [23:0] color);
        t_prim p;
        p.kind = kind;
        p.base = next_base;
        for (int j = 0; j < 8; j++) p.c[j] = c[j][23:0];
        p.color = color;
        p.last = 1'b0;
        expected_prims.push_back(p);
        next_base = next_base + (kind ? 16'd3 : 16'd4);
    endfunction

    // thick line quad, offsets along the normal, signs by quadrant
    function void line_quad(longint x0, longint y0, longint x1, longint y1,
                            longint unsigned t, logic [23:0] color);
        longint unsigned dx, dy, len;
        longint ox, oy, sa, sb;
        longint c[8];
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        len = int_sqrt(dx * dx + dy * dy);
        ox = 0;
        oy = 0;
        if (len != 0) begin
            ox = (t * dy + len) / (2 * len);
            oy = (t * dx + len) / (2 * len);
        end
        if (x1 > x0 && y1 > y0) begin sa = 1; sb = -1; end
        else if (x1 > x0 && y1 < y0) begin sa = -1; sb = -1; end
        else if (x1 < x0 && y1 < y0) begin sa = -1; sb = 1; end
        else begin sa = 1; sb = 1; end
        c[0] = clamp(x0 + sa * ox); c[1] = clamp(y0 + sb * oy);
        c[2] = clamp(x0 - sa * ox); c[3] = clamp(y0 - sb * oy);
        c[4] = clamp(x1 + sa * ox); c[5] = clamp(y1 + sb * oy);
        c[6] = clamp(x1 - sa * ox); c[7] = clamp(y1 - sb * oy);
        push_prim(pt2d_pkg::KIND_QUAD, c, color);
    endfunction

    // point k of a circle cut into n slices, CORDIC rotation on a turn phase
    function void rim_point(longint cx, longint cy, longint r, int k, int n,
                            output longint px, output longint py);
        longint unsigned ph;
        logic [31:0] phase;
        longint x, y, z, nx, co, si;
        ph = (longint'(k % n) << 32) / n;
        phase = ph[31:0];
        z = longint'(phase[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - arc_tbl[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + arc_tbl[i];
            end
            x = nx;
        end
        case (phase[31:30])
            2'd0: begin co = x; si = y; end
            2'd1: begin co = -y; si = x; end
            2'd2: begin co = -x; si = -y; end
            default: begin co = y; si = -x; end
        endcase
        px = clamp(cx + ((r * co + (64'sd1 << 29)) >>> 30));
        py = clamp(cy + ((r * si + (64'sd1 << 29)) >>> 30));
    endfunction

    // accepted command: queue the primitives it must produce
    function void note_command(t_cmd_txn d);
        longint c[8];
        longint x0, y0, x1, y1;
        int n, before_cnt;
        before_cnt = expected_prims.size();
        n = (d.spans > 64) ? 64 : d.spans;
        case (d.cmd)
            pt2d_pkg::CMD_RECT: begin
                c[0] = d.ax; c[1] = d.ay;
                c[2] = d.ax; c[3] = clamp(longint'(d.ay) + d.by);
                c[4] = clamp(longint'(d.ax) + d.bx); c[5] = d.ay;
                c[6] = clamp(longint'(d.ax) + d.bx); c[7] = clamp(longint'(d.ay) + d.by);
                push_prim(pt2d_pkg::KIND_QUAD, c, d.color);
            end
            pt2d_pkg::CMD_LINE: line_quad(d.ax, d.ay, d.bx, d.by, d.thick, d.color);
            pt2d_pkg::CMD_TRI: begin
                c = '{d.ax, d.ay, d.bx, d.by, d.cx, d.cy, 0, 0};
                push_prim(pt2d_pkg::KIND_TRI, c, d.color);
            end
            pt2d_pkg::CMD_FCIRC: for (int i = 0; i < n; i++) begin
                rim_point(d.ax, d.ay, d.radius, i + 1, n, x0, y0);
                rim_point(d.ax, d.ay, d.radius, i + 2, n, x1, y1);
                c = '{d.ax, d.ay, x0, y0, x1, y1, 0, 0};
                push_prim(pt2d_pkg::KIND_TRI, c, d.color);
            end
            pt2d_pkg::CMD_OCIRC: for (int i = 0; i < n; i++) begin
                rim_point(d.ax, d.ay, d.radius, i + 1, n, x0, y0);
                rim_point(d.ax, d.ay, d.radius, i + 2, n, x1, y1);
                line_quad(x0, y0, x1, y1, d.thick, d.color);
            end
            pt2d_pkg::CMD_RESET: next_base = '0;
            default: ;
        endcase
        if (expected_prims.size() > before_cnt)
            expected_prims[$].last = 1'b1;
    endfunction

    function void field_cmp(string name, longint e, longint a);
        if (e != a) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH %s: expected %0h actual %0h", name, e, a);
        end
    endfunction

    // accepted primitive: compare with the oldest expectation
    function void check_prim(t_prim a);
        t_prim e;
        if (expected_prims.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: unexpected primitive, expected none actual base %0h",
                         a.base);
            return;
        end
        e = expected_prims.pop_front();
        field_cmp("prim_kind", e.kind, a.kind);
        field_cmp("base_index", e.base, a.base);
        for (int j = 0; j < 8; j++)
            field_cmp($sformatf("corner%0d_%s", j / 2 + 1, (j % 2) ? "y" : "x"),
                      e.c[j], a.c[j]);
        field_cmp("color_out", e.color, a.color);
        field_cmp("last_of_run", e.last, a.last);
    endfunction
endclass

module testbench;
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_command = '0;
    logic signed [23:0] i_point_a_x = '0, i_point_a_y = '0;
    logic signed [23:0] i_point_b_x = '0, i_point_b_y = '0;
    logic signed [23:0] i_point_c_x = '0, i_point_c_y = '0;
    logic [15:0]        i_line_thickness = '0;
    logic [21:0]        i_radius = '0;
    logic [6:0]         i_span_count = '0;
    logic [23:0]        i_color_rgb = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_prim_kind;
    logic [15:0]        o_base_index;
    logic signed [23:0] o_corner1_x, o_corner1_y, o_corner2_x, o_corner2_y;
    logic signed [23:0] o_corner3_x, o_corner3_y, o_corner4_x, o_corner4_y;
    logic [23:0]        o_color_out;
    logic               o_last_of_run;

    prim_scoreboard sb = new();
    bit             calm = 1'b0;

    primitive_tessellator_2d u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge i_clk)
        i_ready <= calm || ($urandom_range(99) >= 38);

    // observe both channels
    always @(posedge i_clk) begin
        t_cmd_txn d;
        t_prim    p;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                d = '{pt2d_pkg::t_cmd'(i_command), i_point_a_x, i_point_a_y, i_point_b_x,
                      i_point_b_y, i_point_c_x, i_point_c_y, i_line_thickness,
                      i_radius, i_span_count, i_color_rgb};
                sb.note_command(d);
            end
            if (o_valid && i_ready) begin
                p.kind = o_prim_kind;
                p.base = o_base_index;
                p.c = '{o_corner1_x, o_corner1_y, o_corner2_x, o_corner2_y,
                        o_corner3_x, o_corner3_y, o_corner4_x, o_corner4_y};
                p.color = o_color_out;
                p.last = o_last_of_run;
                sb.check_prim(p);
            end
        end
    end

    // one command transaction, with an optional idle gap first
    task automatic send_cmd(t_cmd_txn d);
        if (!calm && $urandom_range(99) < 38) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_command <= d.cmd;
        i_point_a_x <= d.ax; i_point_a_y <= d.ay;
        i_point_b_x <= d.bx; i_point_b_y <= d.by;
        i_point_c_x <= d.cx; i_point_c_y <= d.cy;
        i_line_thickness <= d.thick;
        i_radius <= d.radius;
        i_span_count <= d.spans;
        i_color_rgb <= d.color;
        do @(posedge i_clk); while (!(i_valid && o_ready));
    endtask

    function automatic t_cmd_txn mk(pt2d_pkg::t_cmd c, int ax, int ay, int bx, int by,
                                    int cx, int cy, int t, int r, int n);
        t_cmd_txn d;
        d = '{c, ax[23:0], ay[23:0], bx[23:0], by[23:0], cx[23:0], cy[23:0],
              t[15:0], r[21:0], n[6:0], 24'($urandom())};
        return d;
    endfunction

    function automatic t_cmd_txn rand_cmd();
        t_cmd_txn d;
        int       sel;
        d = '{pt2d_pkg::CMD_RECT, 24'($urandom()), 24'($urandom()), 24'($urandom()),
              24'($urandom()), 24'($urandom()), 24'($urandom()), 16'($urandom()),
              22'($urandom()), 7'($urandom_range(6)), 24'($urandom())};
        sel = $urandom_range(99);
        if (sel < 16) d.cmd = pt2d_pkg::CMD_RECT;
        else if (sel < 38) d.cmd = pt2d_pkg::CMD_LINE;
        else if (sel < 52) d.cmd = pt2d_pkg::CMD_TRI;
        else if (sel < 70) d.cmd = pt2d_pkg::CMD_FCIRC;
        else if (sel < 90) d.cmd = pt2d_pkg::CMD_OCIRC;
        else if (sel < 95) d.cmd = pt2d_pkg::CMD_RESET;
        else d.cmd = pt2d_pkg::t_cmd'($urandom_range(6, 7));
        // mostly small, in-range geometry; a few large spans
        if ($urandom_range(3) != 0) begin
            d.radius = 22'($urandom_range(20000));
            d.ax = $signed(24'($urandom_range(200000))) - 24'sd100000;
            d.ay = $signed(24'($urandom_range(200000))) - 24'sd100000;
            d.thick = 16'($urandom_range(2000));
        end
        if ($urandom_range(99) < 2) d.spans = 7'($urandom_range(64, 127));
        return d;
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: extremes, each quadrant, special cases
        send_cmd(mk(pt2d_pkg::CMD_RECT, 8388607, 8388607, 8388607, 8388607, 0, 0, 0, 0, 0));
        send_cmd(mk(pt2d_pkg::CMD_RECT, -8388608, -8388608, -8388608, -8388608,
                    0, 0, 0, 0, 0));
        send_cmd(mk(pt2d_pkg::CMD_RECT, 100, -200, 3000, 4000, -1, -1, 65535, 4194303, 127));
        send_cmd(mk(pt2d_pkg::CMD_LINE, 0, 0, 1000, 2000, 0, 0, 512, 0, 0));
        send_cmd(mk(pt2d_pkg::CMD_LINE, 0, 0, 1000, -2000, 0, 0, 512, 0, 0));
        send_cmd(mk(pt2d_pkg::CMD_LINE, 0, 0, -1000, -2000, 0, 0, 512, 0, 0));
        send_cmd(mk(pt2d_pkg::CMD_LINE, 0, 0, -1000, 2000, 0, 0, 512, 0, 0));
        send_cmd(mk(pt2d_pkg::CMD_LINE, 500, 500, 500, 500, 0, 0, 65535, 0, 0));
        send_cmd(mk(pt2d_pkg::CMD_LINE, 0, 7, 3000, 7, 0, 0, 300, 0, 0));
        send_cmd(mk(pt2d_pkg::CMD_LINE, 8388607, -8388608, -8388608, 8388607,
                    0, 0, 65535, 0, 0));
        send_cmd(mk(pt2d_pkg::CMD_TRI, 8388607, -8388608, -8388608, 8388607, 1, -1, 0, 0, 0));
        send_cmd(mk(pt2d_pkg::CMD_FCIRC, 0, 0, 0, 0, 0, 0, 0, 2560, 1));
        send_cmd(mk(pt2d_pkg::CMD_FCIRC, -5000, 300, 0, 0, 0, 0, 0, 2560, 3));
        send_cmd(mk(pt2d_pkg::CMD_FCIRC, 0, 0, 0, 0, 0, 0, 0, 2560, 0));
        send_cmd(mk(pt2d_pkg::CMD_OCIRC, 1000, 1000, 0, 0, 0, 0, 0, 2560, 0));
        send_cmd(mk(pt2d_pkg::CMD_OCIRC, 1000, 1000, 0, 0, 0, 0, 256, 2560, 2));
        send_cmd(mk(pt2d_pkg::CMD_FCIRC, 8388000, -8388000, 0, 0, 0, 0, 0, 4194303, 100));
        send_cmd(mk(pt2d_pkg::CMD_OCIRC, -8388000, 8388000, 0, 0, 0, 0, 65535, 4194303, 64));
        send_cmd(mk(pt2d_pkg::CMD_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 5));
        send_cmd(mk(pt2d_pkg::CMD_RSVD6, 1, 2, 3, 4, 5, 6, 7, 8, 9));
        send_cmd(mk(pt2d_pkg::CMD_RSVD7, 1, 2, 3, 4, 5, 6, 7, 8, 9));
        send_cmd(mk(pt2d_pkg::CMD_TRI, 1, 2, 3, 4, 5, 6, 0, 0, 0));

        // random, with a stretch of no idling on either side
        for (int k = 0; k < 440; k++) begin
            calm = (k >= 180 && k < 260);
            send_cmd(rand_cmd());
        end
        calm = 1'b0;
        @(negedge i_clk) i_valid <= 1'b0;

        while (sb.expected_prims.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_prims.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #100000000;
        $display("Verification failed");
        $finish;
    end
endmodule
